// ===== rtl/core/scrolling_strip_chart_histogram_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Strip-chart histogram assertion macros
// Shared concurrent assertion forms for the histogram unit.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_STRIP_CHART_HISTOGRAM_UNIT_MACROS_SVH
`define SCROLLING_STRIP_CHART_HISTOGRAM_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCHIST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCHIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/schist_pkg.sv =====
// ----------------------------------------------------------------------------
// Strip-chart histogram package
// Field widths, mode codes and the shift plan record.
// ----------------------------------------------------------------------------
`default_nettype none

package schist_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned MODE_W  = 2;
  // Wide enough to hold the largest bin count itself.
  localparam int unsigned SHIFT_W = IDX_W + 1;

  localparam logic [MODE_W-1:0] MODE_INCR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

  // Result of the window check for one increment.
  typedef struct packed {
    logic               shift_dn;
    logic               shift_up;
    logic               clear_all;
    logic [SHIFT_W-1:0] shift;
    logic [IDX_W-1:0]   lidx;
    logic [DATA_W-1:0]  offset;
  } plan_t;

endpackage

`default_nettype wire

// ===== rtl/core/schist_in_if.sv =====
// ----------------------------------------------------------------------------
// Strip-chart histogram request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface schist_in_if;
  import schist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic                     present;
  logic signed [DATA_W-1:0] time_coord;
  logic signed [DATA_W-1:0] amount;
  logic [IDX_W-1:0]         bin_index;
  logic [DATA_W-1:0]        write_data;

  modport source (output valid, mode, present, time_coord, amount, bin_index, write_data,
                  input ready);
  modport sink (input valid, mode, present, time_coord, amount, bin_index, write_data,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/schist_out_if.sv =====
// ----------------------------------------------------------------------------
// Strip-chart histogram result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface schist_out_if;
  import schist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        read_data;
  logic signed [DATA_W-1:0] window_offset;
  logic                     index_error;

  modport source (output valid, read_data, window_offset, index_error, input ready);
  modport sink (input valid, read_data, window_offset, index_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/schist_plan.sv =====
// ----------------------------------------------------------------------------
// Strip-chart histogram shift planner
// Registers the window decision for one increment: shift direction, amount,
// landing bin and the new offset.
// ----------------------------------------------------------------------------
`default_nettype none

module schist_plan #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [schist_pkg::DATA_W:0]     diff_i,
  input  wire logic [schist_pkg::DATA_W-1:0]   tc_i,
  input  wire logic [schist_pkg::DATA_W-1:0]   off_i,
  output schist_pkg::plan_t                    plan_o
);
  import schist_pkg::*;

  localparam int unsigned LAND = NUM_BINS - NUM_BINS / 4;
  localparam int unsigned SW   = DATA_W + 2;

  logic          is_dn;
  logic          is_up;
  logic [SW-1:0] s_dn;
  logic [SW-1:0] s_up;
  logic [SW-1:0] s_amt;
  logic          big;
  plan_t         plan_d;
  plan_t         plan_q;

  always_comb begin
    is_up = diff_i[DATA_W];
    is_dn = !diff_i[DATA_W] && (diff_i >= (DATA_W + 1)'(NUM_BINS));
    // Distance that puts the bin at three quarters of the window.
    s_dn  = {1'b0, diff_i} - SW'(LAND);
    // Magnitude of a negative bin.
    s_up  = SW'(0) - {diff_i[DATA_W], diff_i};
    s_amt = is_dn ? s_dn : s_up;
    big   = s_amt >= SW'(NUM_BINS);

    plan_d.shift_dn  = is_dn;
    plan_d.shift_up  = is_up;
    plan_d.clear_all = (is_dn || is_up) && big;
    plan_d.shift     = big ? SHIFT_W'(NUM_BINS) : s_amt[SHIFT_W-1:0];
    priority if (is_dn) begin
      plan_d.lidx   = IDX_W'(LAND);
      plan_d.offset = tc_i - DATA_W'(LAND);
    end else if (is_up) begin
      plan_d.lidx   = '0;
      plan_d.offset = tc_i;
    end else begin
      plan_d.lidx   = diff_i[IDX_W-1:0];
      plan_d.offset = off_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plan_q <= plan_d;
    end
  end

  assign plan_o = plan_q;

endmodule

`default_nettype wire

// ===== rtl/core/scrolling_strip_chart_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// Scrolling strip-chart histogram unit
// Window of NUM_BINS 32-bit bins kept in one ring memory, with increment,
// single-bin read and single-bin write.
// ----------------------------------------------------------------------------
// The unit handles one transaction at a time. After reset it clears the bin
// memory, one entry per cycle, before it takes its first request. An
// increment that scrolls the window also zeroes every bin that it vacates,
// the whole window when all of it is scrolled out: the window is a ring over
// the memory with a base pointer, so no bin is copied, but vacated entries
// are zeroed through the single write port. The finished result sits in an
// output register, so the next request is taken while the previous result
// still waits for the consumer.
`default_nettype none

module scrolling_strip_chart_histogram_unit #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  schist_in_if.sink     req_i,
  schist_out_if.source  rsp_o
);
  import schist_pkg::*;

  `include "scrolling_strip_chart_histogram_unit_macros.svh"

  // Physical address width, and one more bit for counts up to NUM_BINS.
  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] NB_C = CW'(NUM_BINS);

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    S_SWEEP = 9'b000000001,  // zero a run of memory entries
    S_IDLE  = 9'b000000010,  // wait for a request
    S_DIFF  = 9'b000000100,  // bin position relative to the window
    S_PLAN  = 9'b000001000,  // planner registers the shift decision
    S_SHIFT = 9'b000010000,  // move the ring base, set up the sweep
    S_ADDR  = 9'b000100000,  // logical bin to physical address
    S_ACC   = 9'b001000000,  // memory read or write access
    S_WB    = 9'b010000000,  // add and write back, or capture read data
    S_DONE  = 9'b100000000   // hand the result to the output register
  } state_e;

  state_e state_q, state_d;

  // Captured request.
  logic [MODE_W-1:0] mode_q;
  logic              present_q;
  logic [DATA_W-1:0] tc_q;
  logic [DATA_W-1:0] amt_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] wdata_q;

  // Window state: time offset of logical bin 0 and ring base address.
  logic [DATA_W-1:0] offset_q, offset_d;
  logic [AW-1:0]     base_q, base_d;

  // Working registers.
  logic [DATA_W:0]   diff_q, diff_d;
  logic [AW-1:0]     lidx_q, lidx_d;
  logic [AW-1:0]     phys_q, phys_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              init_q, init_d;
  logic              err_q, err_d;
  logic [DATA_W-1:0] res_q, res_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  logic [DATA_W-1:0] out_off_q;
  logic              out_err_q;
  logic              out_load;

  // Bin memory.
  logic [DATA_W-1:0] mem [NUM_BINS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [DATA_W-1:0] mem_rd_q;

  // Shared modulo-NUM_BINS adder over the ring base.
  logic [CW-1:0] wrap_b;
  logic [CW-1:0] wrap_sum;
  logic [CW-1:0] wrap_res;

  plan_t plan;
  logic  accept;
  logic  in_range;

  schist_plan #(
    .NUM_BINS (NUM_BINS)
  ) u_plan (
    .clk_i  (clk_i),
    .en_i   (state_q == S_PLAN),
    .diff_i (diff_q),
    .tc_i   (tc_q),
    .off_i  (offset_q),
    .plan_o (plan)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = {1'b0, idx_q} < (IDX_W + 1)'(NUM_BINS);

  // The base and the addend are both below NUM_BINS, so one conditional
  // subtract brings the sum back into the ring. A downward scroll advances
  // the base by the shift; an upward scroll moves it back, which is the
  // same as advancing it by NUM_BINS minus the shift.
  always_comb begin
    if (state_q == S_SHIFT) begin
      wrap_b = plan.shift_dn ? plan.shift[AW:0] : NB_C - plan.shift[AW:0];
    end else begin
      wrap_b = {1'b0, lidx_q};
    end
    wrap_sum = {1'b0, base_q} + wrap_b;
    wrap_res = (wrap_sum >= NB_C) ? wrap_sum - NB_C : wrap_sum;
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d     = state_q;
    offset_d    = offset_q;
    base_d      = base_q;
    diff_d      = diff_q;
    lidx_d      = lidx_q;
    phys_d      = phys_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    init_d      = init_q;
    err_d       = err_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = phys_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = '0;
        ptr_d     = ({1'b0, ptr_q} == NB_C - CW'(1)) ? '0 : ptr_q + AW'(1);
        cnt_d     = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = init_q ? S_IDLE : S_ADDR;
          init_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        // Exact signed difference; it always fits in one extra bit.
        diff_d = {tc_q[DATA_W-1], tc_q} - {offset_q[DATA_W-1], offset_q};
        err_d  = 1'b0;
        res_d  = '0;
        unique case (mode_q)
          MODE_INCR: begin
            state_d = present_q ? S_PLAN : S_DONE;
          end
          MODE_READ, MODE_WRITE: begin
            if (in_range) begin
              lidx_d  = idx_q[AW-1:0];
              state_d = S_ADDR;
            end else begin
              err_d   = 1'b1;
              state_d = S_DONE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_PLAN: begin
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        offset_d = plan.offset;
        lidx_d   = plan.lidx[AW-1:0];
        priority if (plan.clear_all) begin
          // Whole window scrolled out: zero every entry, base stays.
          ptr_d   = '0;
          cnt_d   = NB_C;
          state_d = S_SWEEP;
        end else if (plan.shift_dn) begin
          // Entries that held the oldest bins become the newest ones.
          ptr_d   = base_q;
          cnt_d   = plan.shift[AW:0];
          base_d  = wrap_res[AW-1:0];
          state_d = S_SWEEP;
        end else if (plan.shift_up) begin
          // Entries that held the newest bins become the oldest ones.
          ptr_d   = wrap_res[AW-1:0];
          cnt_d   = plan.shift[AW:0];
          base_d  = wrap_res[AW-1:0];
          state_d = S_SWEEP;
        end else begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        phys_d  = wrap_res[AW-1:0];
        state_d = S_ACC;
      end
      S_ACC: begin
        if (mode_q == MODE_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = wdata_q;
          state_d   = S_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (mode_q == MODE_INCR) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rd_q + amt_q;
        end else begin
          res_d = mem_rd_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      offset_q    <= '0;
      base_q      <= '0;
      ptr_q       <= '0;
      cnt_q       <= NB_C;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      offset_q    <= offset_d;
      base_q      <= base_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q    <= req_i.mode;
      present_q <= req_i.present;
      tc_q      <= req_i.time_coord;
      amt_q     <= req_i.amount;
      idx_q     <= req_i.bin_index;
      wdata_q   <= req_i.write_data;
    end
    diff_q <= diff_d;
    lidx_q <= lidx_d;
    phys_q <= phys_d;
    err_q  <= err_d;
    res_q  <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
      out_off_q  <= offset_q;
      out_err_q  <= err_q;
    end
  end

  // Bin memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem[phys_q];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_data     = out_data_q;
  assign rsp_o.window_offset = out_off_q;
  assign rsp_o.index_error   = out_err_q;

  // The ring base must always address a real entry.
  `SCHIST_ASSERT_IMPL(a_base_range, 1'b1, ({1'b0, base_q} < NB_C), "ring base out of range")
  // Every memory write, sweep or access, stays inside the ring.
  `SCHIST_ASSERT_IMPL(a_waddr_range, mem_we, ({1'b0, mem_waddr} < NB_C), "write address out of range")
  // A sweep never runs with an exhausted count.
  `SCHIST_ASSERT_IMPL(a_sweep_cnt, (state_q == S_SWEEP), (cnt_q != '0), "sweep with zero count")
  // A result only appears after the sequencer has finished an item.
  `SCHIST_ASSERT_NEXT(a_done_idle, out_load, (state_q == S_IDLE && out_valid_q), "result load lost")

endmodule

`default_nettype wire
